>>> sv/hsfc_pkg.sv
// shared types, constants and helper functions for the half/single converter
// no dependencies; imported by hsfc_pipe_ctrl, the converter top level and the testbench

package hsfc_pkg;

  // pipeline depth: input, decode, shift, output registers
  localparam int NUM_STAGES = 4;

  // request codes
  localparam logic REQ_H2S = 1'b0;
  localparam logic REQ_S2H = 1'b1;

  // exponent constants
  localparam logic [7:0]  SGL_EXP_MAX    = 8'hFF;
  localparam logic [4:0]  HLF_EXP_MAX    = 5'h1F;
  localparam logic [7:0]  EXP_BIAS_DIFF  = 8'd112;
  localparam logic [7:0]  S2H_SUB_LOW    = 8'd102;  // below: flush to zero
  localparam logic [7:0]  S2H_NORM_LOW   = 8'd113;  // from here: half normal
  localparam logic [7:0]  S2H_OVF_LOW    = 8'd143;  // from here: overflow
  localparam logic [7:0]  S2H_SUB_SHIFT  = 8'd126;  // shift = 126 - exponent
  localparam logic [4:0]  S2H_NORM_SHIFT = 5'd13;

  // fixed result patterns (sign excluded)
  localparam logic [14:0] HLF_INF  = 15'h7C00;
  localparam logic [14:0] HLF_QNAN = 15'h7E00;

  // operand class seen by the decode stage
  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_SUB,
    CLS_NORM,
    CLS_INF,
    CLS_NAN
  } cls_t;

  // pipeline control handed from the stage control to the datapath
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctl_t;

  // leading zero count of a nonzero 10-bit mantissa
  function automatic logic [3:0] lzc10(input logic [9:0] m);
    logic [3:0] n;
    logic       found;
    n     = 4'd0;
    found = 1'b0;
    for (int i = 9; i >= 0; i--) begin
      if (!found && m[i]) begin
        n     = 4'(9 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

>>> sv/hsfc_pipe_ctrl.sv
// valid bits and advance logic for the converter pipeline
// depends on hsfc_pkg (NUM_STAGES, pipe_ctl_t)

module hsfc_pipe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               out_stall,
  output hsfc_pkg::pipe_ctl_t ctl
);
  import hsfc_pkg::*;

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] adv;

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    adv[NUM_STAGES-1] = !valid[NUM_STAGES-1] || !out_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !valid[i] || adv[i+1];
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (adv[i]) begin
          valid[i] <= (i == 0) ? in_valid : valid[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign in_stall  = !adv[0];
  assign ctl.load  = adv;
  assign ctl.valid = valid;

endmodule

>>> sv/half_single_float_converter.sv
// Converts IEEE binary16 and binary32 bit patterns, one conversion per transfer. req_type 0
// widens the half in the low 16 bits of operand_bits to single exactly; req_type 1 narrows
// a single to half with round to nearest even, overflow to infinity, flush of values below
// the half subnormal range to signed zero, and every NaN turned into a quiet NaN with
// payload 0x200 (half result in the low 16 bits, upper 16 zero). The pipeline has four
// register stages (input, decode, shift and round bits, output) and takes one transfer per
// cycle while the input is not stalled. A stall at the output holds the output register;
// an earlier stage waits only while every stage after it is full, so the input stalls once
// all four stages are full and the output is stalled.
// depends on hsfc_pkg and hsfc_pipe_ctrl

module half_single_float_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [31:0] operand_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_bits
);
  import hsfc_pkg::*;

  pipe_ctl_t ctl;

  hsfc_pipe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_stall(out_stall),
    .ctl      (ctl)
  );

  // stage 0: input register
  logic        s0_req;
  logic [31:0] s0_op;

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s0_req <= req_type;
      s0_op  <= operand_bits;
    end
  end

  // stage 1: decode class, exponent and shift amount
  logic        s1_req, s1_req_next;
  logic        s1_sign, s1_sign_next;
  cls_t        s1_cls, s1_cls_next;
  logic [23:0] s1_m24, s1_m24_next;
  logic [4:0]  s1_sh, s1_sh_next;
  logic [7:0]  s1_ex, s1_ex_next;

  logic [4:0]  d_hex;
  logic [9:0]  d_hm;
  logic [7:0]  d_rawex;
  logic [22:0] d_mant;

  always_comb begin
    d_hex       = s0_op[14:10];
    d_hm        = s0_op[9:0];
    d_rawex     = s0_op[30:23];
    d_mant      = s0_op[22:0];
    s1_req_next = s0_req;
    s1_sign_next = (s0_req == REQ_H2S) ? s0_op[15] : s0_op[31];
    s1_cls_next = CLS_ZERO;
    s1_m24_next = {14'd0, d_hm};
    s1_sh_next  = {1'b0, lzc10(d_hm)};
    s1_ex_next  = {3'd0, d_hex} + EXP_BIAS_DIFF;
    if (s0_req == REQ_H2S) begin
      // half classes: infinity and NaN share one path, payload kept
      if (d_hex == 5'd0) begin
        s1_cls_next = (d_hm == 10'd0) ? CLS_ZERO : CLS_SUB;
      end else if (d_hex == HLF_EXP_MAX) begin
        s1_cls_next = CLS_INF;
      end else begin
        s1_cls_next = CLS_NORM;
      end
    end else begin
      // single classes by raw exponent range
      s1_ex_next = d_rawex - EXP_BIAS_DIFF;
      if (d_rawex == SGL_EXP_MAX) begin
        s1_cls_next = (d_mant != 23'd0) ? CLS_NAN : CLS_INF;
      end else if (d_rawex >= S2H_OVF_LOW) begin
        s1_cls_next = CLS_INF;
      end else if (d_rawex >= S2H_NORM_LOW) begin
        s1_cls_next = CLS_NORM;
      end else if (d_rawex >= S2H_SUB_LOW) begin
        s1_cls_next = CLS_SUB;
      end else begin
        s1_cls_next = CLS_ZERO;
      end
      if (s1_cls_next == CLS_SUB) begin
        s1_m24_next = {1'b1, d_mant};
        s1_sh_next  = 5'(S2H_SUB_SHIFT - d_rawex);
      end else begin
        s1_m24_next = {1'b0, d_mant};
        s1_sh_next  = S2H_NORM_SHIFT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      s1_req  <= s1_req_next;
      s1_sign <= s1_sign_next;
      s1_cls  <= s1_cls_next;
      s1_m24  <= s1_m24_next;
      s1_sh   <= s1_sh_next;
      s1_ex   <= s1_ex_next;
    end
  end

  // stage 2: finish the widening, or shift out the narrowed mantissa
  logic        s2_req, s2_req_next;
  logic [31:0] s2_word, s2_word_next;
  logic        s2_rnd, s2_rnd_next;

  logic [47:0] w_shift;
  logic [9:0]  w_q;
  logic        w_guard;
  logic        w_sticky;
  logic [9:0]  w_norm;
  logic [9:0]  w_hm_sh;
  logic [7:0]  w_sub_ex;
  logic [14:0] w_base;

  always_comb begin
    // narrowing: quotient, guard bit and sticky bits in one right shift
    w_shift  = {s1_m24, 24'd0} >> s1_sh;
    w_q      = w_shift[33:24];
    w_guard  = w_shift[23];
    w_sticky = |w_shift[22:0];
    // widening: subnormal half normalized by the leading zero count
    w_hm_sh  = s1_m24[9:0] << s1_sh[3:0];
    w_norm   = {w_hm_sh[8:0], 1'b0};
    w_sub_ex = EXP_BIAS_DIFF - {4'd0, s1_sh[3:0]};

    s2_req_next = s1_req;
    s2_rnd_next = 1'b0;
    w_base      = 15'd0;
    s2_word_next = {s1_sign, 31'd0};
    if (s1_req == REQ_H2S) begin
      case (s1_cls)
        CLS_SUB:  s2_word_next = {s1_sign, w_sub_ex, w_norm, 13'd0};
        CLS_NORM: s2_word_next = {s1_sign, s1_ex, s1_m24[9:0], 13'd0};
        CLS_INF:  s2_word_next = {s1_sign, SGL_EXP_MAX, s1_m24[9:0], 13'd0};
        default:  s2_word_next = {s1_sign, 31'd0};
      endcase
    end else begin
      case (s1_cls)
        CLS_SUB:  w_base = {5'd0, w_q};
        CLS_NORM: w_base = {s1_ex[4:0], w_q};
        CLS_INF:  w_base = HLF_INF;
        CLS_NAN:  w_base = HLF_QNAN;
        default:  w_base = 15'd0;
      endcase
      // nearest even: above half, or exactly half with an odd quotient
      if (s1_cls == CLS_SUB || s1_cls == CLS_NORM) begin
        s2_rnd_next = w_guard && (w_sticky || w_q[0]);
      end
      s2_word_next = {16'd0, s1_sign, w_base};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      s2_req  <= s2_req_next;
      s2_word <= s2_word_next;
      s2_rnd  <= s2_rnd_next;
    end
  end

  // stage 3: rounding increment for narrowing, carry runs into the exponent
  logic [31:0] s3_res_next;
  logic [14:0] r_mag;

  always_comb begin
    r_mag = s2_word[14:0] + {14'd0, s2_rnd};
    if (s2_req == REQ_S2H) begin
      s3_res_next = {16'd0, s2_word[15], r_mag};
    end else begin
      s3_res_next = s2_word;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      result_bits <= s3_res_next;
    end
  end

  assign out_valid = ctl.valid[NUM_STAGES-1];

endmodule

>>> sv/hsfc_checker.sv
// port-level checks for the half/single converter, bound to the top level
// depends on half_single_float_converter ports only

module hsfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        req_type,
  input logic [31:0] operand_bits,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] result_bits
);

  // a held result stays in place
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_bits))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // with the output not stalled after it, a transfer reaches the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("transfer did not reach output in four cycles");

  // output free means the input is free once the pipeline can drain
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !out_stall |-> !in_stall || out_valid)
    else $error("input stalled with an empty output stage");

endmodule

bind half_single_float_converter hsfc_checker u_hsfc_checker (.*);

>>> bench/tb_half_single_float_converter.sv
// testbench for the half/single float converter: directed corner patterns, then random traffic
// with random gaps and stalls on both channels, checked in order against a local predictor
// depends on hsfc_pkg and half_single_float_converter
`timescale 1ns / 1ps

module tb_half_single_float_converter;
  import hsfc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int ERR_SHOWN    = 10;
  localparam int STEADY_FIRST = 320;
  localparam int STEADY_LAST  = 440;

  typedef struct {
    logic        req;
    logic [31:0] operand;
  } conv_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = REQ_H2S;
  logic [31:0] operand_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] result_bits;

  conv_item_t  pending_items[$];
  logic [31:0] expected_results[$];
  int          accepted_cnt = 0;
  int          h2s_cnt = 0;
  int          s2h_cnt = 0;
  int          checked_cnt = 0;
  int          error_cnt = 0;
  int          cycle_cnt = 0;

  // no gaps and no stalls over one stretch of the run
  wire steady = (accepted_cnt >= STEADY_FIRST) && (accepted_cnt < STEADY_LAST);

  half_single_float_converter uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .operand_bits (operand_bits),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_bits  (result_bits)
  );

  always #10 clk = ~clk;

  // exact widening of a half pattern to single
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [4:0]  e;
    logic [10:0] m;
    int          shifts;
    e      = h[14:10];
    m      = {1'b0, h[9:0]};
    shifts = 0;
    if (e == 5'd0) begin
      if (m == 11'd0) return {h[15], 31'b0};
      // normalize the subnormal until the hidden bit shows up
      while (!m[10]) begin
        m = m << 1;
        shifts++;
      end
      return {h[15], 8'(113 - shifts), m[9:0], 13'b0};
    end
    if (e == HLF_EXP_MAX) return {h[15], SGL_EXP_MAX, m[9:0], 13'b0};
    return {h[15], 8'(int'(e) + 112), m[9:0], 13'b0};
  endfunction

  // narrowing of a single pattern to half, nearest even
  function automatic logic [15:0] narrow_single(input logic [31:0] f);
    logic        sgn;
    logic [7:0]  rawex;
    logic [31:0] q;
    logic [31:0] rem;
    logic [31:0] halfway;
    logic [31:0] full;
    int          ex;
    int          sh;
    sgn   = f[31];
    rawex = f[30:23];
    ex    = int'(rawex) - 112;
    if (rawex == SGL_EXP_MAX) return {sgn, (f[22:0] != 0) ? HLF_QNAN : HLF_INF};
    if (ex >= 31) return {sgn, HLF_INF};
    // half subnormal range, or flush to zero below it
    if (ex <= 0) begin
      if (ex < -10) return {sgn, 15'b0};
      full    = {8'b0, 1'b1, f[22:0]};
      sh      = 14 - ex;
      q       = full >> sh;
      rem     = full & ((32'd1 << sh) - 32'd1);
      halfway = 32'd1 << (sh - 1);
      if (rem > halfway || (rem == halfway && q[0])) q = q + 32'd1;
      return {sgn, q[14:0]};
    end
    // normal range, a carry out of the mantissa bumps the exponent
    q   = {22'b0, f[22:13]};
    rem = {19'b0, f[12:0]};
    if (rem > 32'h1000 || (rem == 32'h1000 && q[0])) q = q + 32'd1;
    if (q == 32'h400) return {sgn, 5'(ex + 1), 10'b0};
    return {sgn, 5'(ex), q[9:0]};
  endfunction

  function automatic logic [31:0] converted_pattern(input logic req, input logic [31:0] operand);
    if (req == REQ_H2S) return widen_half(operand[15:0]);
    return {16'b0, narrow_single(operand)};
  endfunction

  // random half with exponents weighted toward zero and all ones, junk in the upper half
  function automatic logic [31:0] random_half_word();
    logic [4:0] e;
    logic [9:0] m;
    case ($urandom_range(3))
      0: e = 5'd0;
      1: e = HLF_EXP_MAX;
      default: e = 5'($urandom);
    endcase
    m = 10'($urandom);
    if ($urandom_range(7) == 0) m = '0;
    return {16'($urandom), 1'($urandom), e, m};
  endfunction

  // random single aimed at the flush, subnormal, rounding and overflow boundaries
  function automatic logic [31:0] random_single();
    logic [7:0]  e;
    logic [22:0] m;
    int          sh;
    case ($urandom_range(9))
      0: e = SGL_EXP_MAX;
      1: e = 8'd0;
      2, 3: e = 8'($urandom_range(S2H_NORM_LOW - 1, S2H_SUB_LOW - 1));
      4, 5: e = 8'($urandom_range(S2H_OVF_LOW - 1, S2H_NORM_LOW));
      6: e = 8'($urandom_range(S2H_OVF_LOW + 1, S2H_OVF_LOW - 2));
      default: e = 8'($urandom);
    endcase
    m = 23'($urandom);
    case ($urandom_range(5))
      0: m = '0;
      1: begin
        // exact tie at the rounding position
        if (e >= S2H_NORM_LOW) begin
          m[12:0] = 13'h1000;
        end else if (e >= S2H_SUB_LOW) begin
          sh = int'(S2H_SUB_SHIFT) - int'(e);
          if (sh >= 24) m = '0;
          else m = (m & ~((23'd1 << sh) - 23'd1)) | (23'd1 << (sh - 1));
        end
      end
      2: m[12:0] = 13'h1FFF;
      3: m = '1;
      default: ;
    endcase
    return {1'($urandom), e, m};
  endfunction

  task automatic queue_item(input logic req, input logic [31:0] operand);
    conv_item_t it;
    it.req     = req;
    it.operand = operand;
    pending_items.push_back(it);
  endtask

  task automatic queue_random(input int count);
    logic req;
    for (int i = 0; i < count; i++) begin
      req = 1'($urandom_range(1));
      queue_item(req, (req == REQ_H2S) ? random_half_word() : random_single());
    end
  endtask

  task automatic note_error(input string msg);
    error_cnt++;
    if (error_cnt <= ERR_SHOWN) $display("%0s", msg);
  endtask

  // sender: records the expected result of each transfer and presents the next item
  always @(posedge clk) begin : driver_proc
    conv_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(converted_pattern(req_type, operand_bits));
        accepted_cnt++;
        if (req_type == REQ_H2S) h2s_cnt++;
        else s2h_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 17)) begin
          nxt = pending_items.pop_front();
          in_valid     <= 1'b1;
          req_type     <= nxt.req;
          operand_bits <= nxt.operand;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: compares each result transfer with the oldest expectation
  always @(posedge clk) begin : monitor_proc
    logic [31:0] want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          note_error($sformatf("result %08h arrived with nothing outstanding", result_bits));
        end else begin
          want = expected_results.pop_front();
          checked_cnt++;
          if (result_bits !== want)
            note_error($sformatf("result %0d: expected %08h got %08h",
                                 checked_cnt, want, result_bits));
        end
      end
      out_stall <= !steady && ($urandom_range(99) < 17);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // half to single corners: zeros, subnormals, extremes, infinities, nans, junk upper half
    queue_item(REQ_H2S, 32'h0000_0000);
    queue_item(REQ_H2S, 32'h0000_8000);
    queue_item(REQ_H2S, 32'h0000_0001);
    queue_item(REQ_H2S, 32'h0000_83FF);
    queue_item(REQ_H2S, 32'h0000_0400);
    queue_item(REQ_H2S, 32'h0000_7BFF);
    queue_item(REQ_H2S, 32'h0000_FC00);
    queue_item(REQ_H2S, 32'h0000_7E00);
    queue_item(REQ_H2S, 32'h0000_7C01);
    queue_item(REQ_H2S, 32'hABCD_3C00);
    // single to half corners: signed zero, single subnormal, infinity, nans
    queue_item(REQ_S2H, 32'h8000_0000);
    queue_item(REQ_S2H, 32'h0000_0001);
    queue_item(REQ_S2H, 32'h7F80_0000);
    queue_item(REQ_S2H, 32'hFF80_0001);
    queue_item(REQ_S2H, 32'h7FFF_FFFF);
    // largest finite, rounding carry into infinity, plain overflow
    queue_item(REQ_S2H, 32'h477F_E000);
    queue_item(REQ_S2H, 32'h477F_F000);
    queue_item(REQ_S2H, 32'hC780_0000);
    // ties to even in the normal range
    queue_item(REQ_S2H, 32'h3F80_1000);
    queue_item(REQ_S2H, 32'h3F80_3000);
    // half of the smallest subnormal, just above it, carry into smallest normal, flush
    queue_item(REQ_S2H, 32'h3300_0000);
    queue_item(REQ_S2H, 32'h3300_0001);
    queue_item(REQ_S2H, 32'h387F_FFFF);
    queue_item(REQ_S2H, 32'h32FF_FFFF);
    queue_item(REQ_S2H, 32'h0000_0000);

    queue_random(250);

    // hold the sender until the pipeline has fully drained
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);

    queue_random(300);

    @(negedge clk);
    while (pending_items.size() != 0 || in_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (NUM_STAGES * 4) @(negedge clk);

    if (expected_results.size() != 0)
      note_error($sformatf("%0d results never arrived", expected_results.size()));
    $display("converted %0d half-to-single and %0d single-to-half operands, %0d results checked",
             h2s_cnt, s2h_cnt, checked_cnt);
    $display("%0d errors in total", error_cnt);
    if (error_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/hsfc_pkg.sv
sv/hsfc_pipe_ctrl.sv
sv/half_single_float_converter.sv
sv/hsfc_checker.sv
bench/tb_half_single_float_converter.sv
